// File: sv/hrbp_pkg.sv
`default_nettype none
package hrbp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int CL_NAME_LEN = 14;
  localparam logic [3:0] NO_MATCH = 4'd15;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [4:0] {
    ST_START, ST_METHOD, ST_URI, ST_VER_H, ST_VER_T1, ST_VER_T2, ST_VER_P,
    ST_VER_SLASH, ST_MAJ_START, ST_MAJ, ST_MIN_START, ST_MIN, ST_NL1,
    ST_LINE_START, ST_LWS, ST_NAME, ST_SPACE, ST_VALUE, ST_NL2, ST_NL3,
    ST_BODY, ST_DONE, ST_ERROR
  } parse_state_t;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_METHOD = 4'd1, ERR_URI_CTL = 4'd2, ERR_VERSION = 4'd3,
    ERR_DIGIT = 4'd4, ERR_LF = 4'd5, ERR_HDR_NAME = 4'd6, ERR_VAL_CTL = 4'd7,
    ERR_BODY = 4'd8
  } err_code_t;

  typedef enum logic [2:0] {
    CLS_DELIM = 3'd0, CLS_METHOD = 3'd1, CLS_URI = 3'd2, CLS_NAME = 3'd3,
    CLS_VALUE = 3'd4, CLS_BODY = 3'd5
  } byte_cls_t;

  // per-octet character classes computed by the front end
  typedef struct packed {
    logic restart;
    logic [7:0] data;
    logic is_ctl;
    logic is_digit;
    logic is_token;
    logic is_sp;
    logic is_tab;
    logic is_cr;
    logic is_lf;
    logic [7:0] lower;
    logic [3:0] digit;
  } cls_word_t;

  function automatic logic [7:0] cl_name_char(input logic [3:0] pos);
    case (pos)
      4'd0: cl_name_char = "c";
      4'd1: cl_name_char = "o";
      4'd2: cl_name_char = "n";
      4'd3: cl_name_char = "t";
      4'd4: cl_name_char = "e";
      4'd5: cl_name_char = "n";
      4'd6: cl_name_char = "t";
      4'd7: cl_name_char = "-";
      4'd8: cl_name_char = "l";
      4'd9: cl_name_char = "e";
      4'd10: cl_name_char = "n";
      4'd11: cl_name_char = "g";
      4'd12: cl_name_char = "t";
      4'd13: cl_name_char = "h";
      default: cl_name_char = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: sv/hrbp_if.sv
`default_nettype none
interface hrbp_in_if;
  logic valid;
  logic ready;
  logic func;
  logic [7:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink (input valid, func, data_byte, output ready);
endinterface

interface hrbp_out_if;
  logic valid;
  logic ready;
  logic [2:0] byte_class;
  logic [7:0] data_out;
  logic new_header;
  logic done_res;
  logic [3:0] error_code;
  logic [7:0] version_major;
  logic [7:0] version_minor;
  logic [31:0] body_length;
  modport source (output valid, byte_class, data_out, new_header, done_res, error_code,
                  version_major, version_minor, body_length, input ready);
  modport sink (input valid, byte_class, data_out, new_header, done_res, error_code,
                version_major, version_minor, body_length, output ready);
endinterface
`default_nettype wire

// File: sv/hrbp_front.sv
`default_nettype none
module hrbp_front (
  hrbp_in_if.sink in_ch,
  output hrbp_pkg::cls_word_t q_wdata,
  output logic q_push,
  input  wire logic q_full
);
  logic [7:0] c;
  logic special;

  assign c = in_ch.data_byte;
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full;

  // separator characters of the token grammar
  always_comb begin
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
      "=", "{", "}", " ", 8'h09: special = 1'b1;
      default: special = 1'b0;
    endcase
  end

  // classify the octet
  always_comb begin
    q_wdata.restart = in_ch.func;
    q_wdata.data = c;
    q_wdata.is_ctl = (c <= 8'd31) || (c == 8'd127);
    q_wdata.is_digit = (c >= "0") && (c <= "9");
    q_wdata.is_token = !c[7] && !q_wdata.is_ctl && !special;
    q_wdata.is_sp = (c == " ");
    q_wdata.is_tab = (c == 8'h09);
    q_wdata.is_cr = (c == 8'h0d);
    q_wdata.is_lf = (c == 8'h0a);
    q_wdata.lower = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    q_wdata.digit = c[3:0];
  end
endmodule
`default_nettype wire

// File: sv/hrbp_queue.sv
`default_nettype none
module hrbp_queue #(
  parameter int DEPTH = hrbp_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  hrbp_pkg::cls_word_t wdata,
  output logic full,
  input  wire logic pop,
  output hrbp_pkg::cls_word_t rdata,
  output logic not_empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  hrbp_pkg::cls_word_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata = mem[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count overflow");
endmodule
`default_nettype wire

// File: sv/hrbp_back.sv
`default_nettype none
module hrbp_back #(
  parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic body_required,
  input  hrbp_pkg::cls_word_t w,
  input  wire logic w_valid,
  output logic w_pop,
  hrbp_out_if.source out_ch
);
  localparam logic [LENGTH_BITS-1:0] LMAX = '1;
  localparam logic [LENGTH_BITS-1:0] LIM = LMAX / 10;
  localparam logic [3:0] LREM = 4'(LMAX % 10);

  hrbp_pkg::parse_state_t st_r, st_nxt;
  logic [7:0] maj_r, maj_nxt, min_r, min_nxt;
  logic any_r, any_nxt, inlen_r, inlen_nxt, lval_r, lval_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [LENGTH_BITS-1:0] clen_r, clen_nxt, bcnt_r, bcnt_nxt, bcnt_inc;
  hrbp_pkg::err_code_t err_r, err_nxt;
  logic [2:0] cls;
  logic newh;

  logic ov_r;
  logic [2:0] cls_r;
  logic [7:0] dat_r;
  logic newh_r, done_r;
  logic [3:0] eo_r;
  logic [7:0] majo_r, mino_r;
  logic [31:0] blen_r;

  logic adv;
  logic [11:0] maj10, min10;
  logic [LENGTH_BITS+3:0] clen10;
  logic [3:0] pos_m;
  logic [31:0] blen_w;

  assign adv = w_valid && (!ov_r || out_ch.ready);
  assign w_pop = adv;
  assign maj10 = {4'd0, maj_r} * 12'd10 + {8'd0, w.digit};
  assign min10 = {4'd0, min_r} * 12'd10 + {8'd0, w.digit};
  assign clen10 = {4'd0, clen_r} * (LENGTH_BITS+4)'(10) + (LENGTH_BITS+4)'(w.digit);
  assign bcnt_inc = bcnt_r + 1'b1;

  // name match step against the length header name
  always_comb begin
    if (pos_r < 4'(hrbp_pkg::CL_NAME_LEN) && w.lower == hrbp_pkg::cl_name_char(pos_r))
      pos_m = pos_r + 1'b1;
    else
      pos_m = hrbp_pkg::NO_MATCH;
  end

  // parse state machine
  always_comb begin
    st_nxt = st_r; maj_nxt = maj_r; min_nxt = min_r; any_nxt = any_r;
    pos_nxt = pos_r; inlen_nxt = inlen_r; lval_nxt = lval_r; clen_nxt = clen_r;
    bcnt_nxt = bcnt_r; err_nxt = err_r;
    cls = hrbp_pkg::CLS_DELIM; newh = 1'b0;
    case (st_r)
      hrbp_pkg::ST_START: begin
        if (w.is_token) begin
          cls = hrbp_pkg::CLS_METHOD; st_nxt = hrbp_pkg::ST_METHOD;
        end else begin
          err_nxt = hrbp_pkg::ERR_METHOD; st_nxt = hrbp_pkg::ST_ERROR;
        end
      end
      hrbp_pkg::ST_METHOD: begin
        if (w.is_sp) st_nxt = hrbp_pkg::ST_URI;
        else if (w.is_token) cls = hrbp_pkg::CLS_METHOD;
        else begin
          err_nxt = hrbp_pkg::ERR_METHOD; st_nxt = hrbp_pkg::ST_ERROR;
        end
      end
      hrbp_pkg::ST_URI: begin
        if (w.is_sp) st_nxt = hrbp_pkg::ST_VER_H;
        else if (w.is_ctl) begin
          err_nxt = hrbp_pkg::ERR_URI_CTL; st_nxt = hrbp_pkg::ST_ERROR;
        end else cls = hrbp_pkg::CLS_URI;
      end
      hrbp_pkg::ST_VER_H, hrbp_pkg::ST_VER_T1, hrbp_pkg::ST_VER_T2,
      hrbp_pkg::ST_VER_P: begin
        if ((st_r == hrbp_pkg::ST_VER_H && w.data == "H") ||
            (st_r == hrbp_pkg::ST_VER_T1 && w.data == "T") ||
            (st_r == hrbp_pkg::ST_VER_T2 && w.data == "T") ||
            (st_r == hrbp_pkg::ST_VER_P && w.data == "P"))
          st_nxt = hrbp_pkg::parse_state_t'(st_r + 5'd1);
        else begin
          err_nxt = hrbp_pkg::ERR_VERSION; st_nxt = hrbp_pkg::ST_ERROR;
        end
      end
      hrbp_pkg::ST_VER_SLASH: begin
        if (w.data == "/") begin
          maj_nxt = '0; min_nxt = '0; st_nxt = hrbp_pkg::ST_MAJ_START;
        end else begin
          err_nxt = hrbp_pkg::ERR_VERSION; st_nxt = hrbp_pkg::ST_ERROR;
        end
      end
      hrbp_pkg::ST_MAJ_START, hrbp_pkg::ST_MAJ: begin
        if (st_r == hrbp_pkg::ST_MAJ && w.data == ".") st_nxt = hrbp_pkg::ST_MIN_START;
        else if (w.is_digit) begin
          maj_nxt = (maj10 > 12'd255) ? 8'd255 : maj10[7:0];
          st_nxt = hrbp_pkg::ST_MAJ;
        end else begin
          err_nxt = hrbp_pkg::ERR_DIGIT; st_nxt = hrbp_pkg::ST_ERROR;
        end
      end
      hrbp_pkg::ST_MIN_START, hrbp_pkg::ST_MIN: begin
        if (st_r == hrbp_pkg::ST_MIN && w.is_cr) st_nxt = hrbp_pkg::ST_NL1;
        else if (w.is_digit) begin
          min_nxt = (min10 > 12'd255) ? 8'd255 : min10[7:0];
          st_nxt = hrbp_pkg::ST_MIN;
        end else begin
          err_nxt = hrbp_pkg::ERR_DIGIT; st_nxt = hrbp_pkg::ST_ERROR;
        end
      end
      hrbp_pkg::ST_NL1, hrbp_pkg::ST_NL2: begin
        if (w.is_lf) st_nxt = hrbp_pkg::ST_LINE_START;
        else begin
          err_nxt = hrbp_pkg::ERR_LF; st_nxt = hrbp_pkg::ST_ERROR;
        end
      end
      hrbp_pkg::ST_LINE_START: begin
        if (w.is_cr) st_nxt = hrbp_pkg::ST_NL3;
        else if (any_r && (w.is_sp || w.is_tab)) st_nxt = hrbp_pkg::ST_LWS;
        else if (!w.is_token) begin
          err_nxt = hrbp_pkg::ERR_HDR_NAME; st_nxt = hrbp_pkg::ST_ERROR;
        end else begin
          any_nxt = 1'b1; inlen_nxt = 1'b0;
          pos_nxt = (w.lower == hrbp_pkg::cl_name_char(4'd0)) ? 4'd1 : hrbp_pkg::NO_MATCH;
          cls = hrbp_pkg::CLS_NAME; newh = 1'b1; st_nxt = hrbp_pkg::ST_NAME;
        end
      end
      hrbp_pkg::ST_NAME: begin
        if (w.data == ":") begin
          if (pos_r == 4'(hrbp_pkg::CL_NAME_LEN)) begin
            inlen_nxt = 1'b1; lval_nxt = 1'b0; clen_nxt = '0;
          end
          st_nxt = hrbp_pkg::ST_SPACE;
        end else if (w.is_token) begin
          pos_nxt = pos_m; cls = hrbp_pkg::CLS_NAME;
        end else begin
          err_nxt = hrbp_pkg::ERR_HDR_NAME; st_nxt = hrbp_pkg::ST_ERROR;
        end
      end
      hrbp_pkg::ST_SPACE, hrbp_pkg::ST_LWS, hrbp_pkg::ST_VALUE: begin
        if (w.is_cr) st_nxt = hrbp_pkg::ST_NL2;
        else if (st_r != hrbp_pkg::ST_VALUE &&
                 (w.is_sp || (st_r == hrbp_pkg::ST_LWS && w.is_tab))) begin
          // skipped whitespace
        end else if (w.is_ctl) begin
          err_nxt = hrbp_pkg::ERR_VAL_CTL; st_nxt = hrbp_pkg::ST_ERROR;
        end else begin
          if (inlen_r) begin
            if (w.is_digit && (clen_r < LIM || (clen_r == LIM && w.digit <= LREM))) begin
              clen_nxt = clen10[LENGTH_BITS-1:0]; lval_nxt = 1'b1;
            end else begin
              inlen_nxt = 1'b0; lval_nxt = 1'b0; clen_nxt = '0;
            end
          end
          cls = hrbp_pkg::CLS_VALUE; st_nxt = hrbp_pkg::ST_VALUE;
        end
      end
      hrbp_pkg::ST_NL3: begin
        if (!w.is_lf) begin
          err_nxt = hrbp_pkg::ERR_LF; st_nxt = hrbp_pkg::ST_ERROR;
        end else if (lval_r) begin
          bcnt_nxt = '0;
          st_nxt = (clen_r != '0) ? hrbp_pkg::ST_BODY : hrbp_pkg::ST_DONE;
        end else if (body_required) begin
          err_nxt = hrbp_pkg::ERR_BODY; st_nxt = hrbp_pkg::ST_ERROR;
        end else st_nxt = hrbp_pkg::ST_DONE;
      end
      hrbp_pkg::ST_BODY: begin
        cls = hrbp_pkg::CLS_BODY;
        bcnt_nxt = bcnt_inc;
        if (bcnt_inc >= clen_r) st_nxt = hrbp_pkg::ST_DONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    blen_w = '0;
    if (lval_nxt) blen_w = 32'(clen_nxt);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n || (adv && w.restart)) begin
      st_r <= hrbp_pkg::ST_START; maj_r <= '0; min_r <= '0; any_r <= 1'b0;
      pos_r <= '0; inlen_r <= 1'b0; lval_r <= 1'b0; clen_r <= '0; bcnt_r <= '0;
      err_r <= hrbp_pkg::ERR_NONE;
    end else if (adv) begin
      st_r <= st_nxt; maj_r <= maj_nxt; min_r <= min_nxt; any_r <= any_nxt;
      pos_r <= pos_nxt; inlen_r <= inlen_nxt; lval_r <= lval_nxt; clen_r <= clen_nxt;
      bcnt_r <= bcnt_nxt; err_r <= err_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r <= w.data;
      if (w.restart) begin
        cls_r <= '0; newh_r <= 1'b0; done_r <= 1'b0; eo_r <= '0;
        majo_r <= '0; mino_r <= '0; blen_r <= '0;
      end else begin
        cls_r <= cls; newh_r <= newh; done_r <= (st_nxt == hrbp_pkg::ST_DONE);
        eo_r <= err_nxt; majo_r <= maj_nxt; mino_r <= min_nxt; blen_r <= blen_w;
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.byte_class = cls_r;
  assign out_ch.data_out = dat_r;
  assign out_ch.new_header = newh_r;
  assign out_ch.done_res = done_r;
  assign out_ch.error_code = eo_r;
  assign out_ch.version_major = majo_r;
  assign out_ch.version_minor = mino_r;
  assign out_ch.body_length = blen_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == hrbp_pkg::ST_ERROR) |-> (err_r != hrbp_pkg::ERR_NONE))
    else $error("error state without code");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != hrbp_pkg::ST_ERROR) |-> (err_r == hrbp_pkg::ERR_NONE))
    else $error("error code outside error state");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |-> !adv)
    else $error("result overwritten while stalled");
endmodule
`default_nettype wire

// File: sv/http_request_byte_parser.sv
// result path: each accepted byte is written into the queue, then parsed into the output register
// throughput: one byte per cycle unless out_ch.ready stalls the output register of the back end
// a two-entry queue between classifier and parser absorbs output stalls
// reset: synchronous active-low rst_n clears parse state, queue and body_required
`default_nettype none
module http_request_byte_parser #(
  parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hrbp_in_if.sink in_ch,
  hrbp_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  hrbp_pkg::cls_word_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_ne;
  logic body_req_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) body_req_r <= 1'b0;
    else if (cfg_we) body_req_r <= cfg_wdata;
  end

  hrbp_front u_front (
    .in_ch(in_ch),
    .q_wdata(q_wdata), .q_push(q_push), .q_full(q_full)
  );

  hrbp_queue #(.DEPTH(hrbp_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .not_empty(q_ne)
  );

  hrbp_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .body_required(body_req_r),
    .w(q_rdata), .w_valid(q_ne), .w_pop(q_pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// File: tb/tb_http_request_byte_parser.sv
`timescale 1ns / 100ps
module tb_http_request_byte_parser;

  localparam logic [7:0] CR = 8'h0d;
  localparam logic [7:0] LF = 8'h0a;
  localparam logic [7:0] HT = 8'h09;
  localparam logic [8*14-1:0] LEN_HDR = "content-length";
  localparam int LEN_HDR_CHARS = 14;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic func;
    logic [7:0] octet;
  } req_word_t;

  typedef struct packed {
    logic [2:0] byte_class;
    logic [7:0] data_out;
    logic new_header;
    logic done_res;
    logic [3:0] error_code;
    logic [7:0] version_major;
    logic [7:0] version_minor;
    logic [31:0] body_length;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  hrbp_in_if in_ch();
  hrbp_out_if out_ch();

  http_request_byte_parser dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  req_word_t pending_words[$];
  parse_result_t expected_results[$];
  logic [7:0] msg_buf[$];
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  // parser copy kept by the testbench
  logic body_req;
  hrbp_pkg::parse_state_t st;
  logic [7:0] maj, minr;
  logic hdr_seen, in_len, len_ok;
  logic [3:0] match_pos;
  logic [63:0] clen, bcount;
  logic [3:0] err;

  function automatic bit chr_ctl(logic [7:0] c);
    return c <= 8'd31 || c == 8'd127;
  endfunction

  function automatic bit chr_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit chr_token(logic [7:0] c);
    bit sep;
    sep = c inside {"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
                    "?", "=", "{", "}", " ", HT};
    return c < 8'd128 && !chr_ctl(c) && !sep;
  endfunction

  function automatic logic [7:0] sat_mul10(logic [7:0] v, logic [7:0] c);
    int n;
    n = int'(v) * 10 + int'(c - "0");
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  task automatic clear_parser();
    st = hrbp_pkg::ST_START; maj = '0; minr = '0; hdr_seen = 0; match_pos = '0;
    in_len = 0; len_ok = 0; clen = '0; bcount = '0; err = hrbp_pkg::ERR_NONE;
  endtask

  task automatic fail_with(hrbp_pkg::err_code_t code);
    err = code;
    st = hrbp_pkg::ST_ERROR;
  endtask

  task automatic match_name(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (match_pos < LEN_HDR_CHARS && lc == LEN_HDR[8*(LEN_HDR_CHARS-1-match_pos) +: 8])
      match_pos = match_pos + 1'b1;
    else
      match_pos = hrbp_pkg::NO_MATCH;
  endtask

  // digit accumulation for the content-length value
  task automatic length_octet(logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - "0");
    if (!in_len) return;
    if (chr_digit(c) && clen <= (64'hFFFF_FFFF - d) / 10) begin
      clen = clen * 10 + d;
      len_ok = 1;
    end else begin
      in_len = 0; len_ok = 0; clen = '0;
    end
  endtask

  task automatic parse_word(input req_word_t w, output parse_result_t r);
    logic [7:0] c;
    hrbp_pkg::byte_cls_t cls;
    logic nh;
    c = w.octet;
    cls = hrbp_pkg::CLS_DELIM;
    nh = 1'b0;
    if (w.func) begin
      clear_parser();
      r = '0;
      r.data_out = c;
      return;
    end
    case (st)
      hrbp_pkg::ST_START: begin
        if (chr_token(c)) begin cls = hrbp_pkg::CLS_METHOD; st = hrbp_pkg::ST_METHOD; end
        else fail_with(hrbp_pkg::ERR_METHOD);
      end
      hrbp_pkg::ST_METHOD: begin
        if (c == " ") st = hrbp_pkg::ST_URI;
        else if (chr_token(c)) cls = hrbp_pkg::CLS_METHOD;
        else fail_with(hrbp_pkg::ERR_METHOD);
      end
      hrbp_pkg::ST_URI: begin
        if (c == " ") st = hrbp_pkg::ST_VER_H;
        else if (chr_ctl(c)) fail_with(hrbp_pkg::ERR_URI_CTL);
        else cls = hrbp_pkg::CLS_URI;
      end
      hrbp_pkg::ST_VER_H:
        if (c == "H") st = hrbp_pkg::ST_VER_T1; else fail_with(hrbp_pkg::ERR_VERSION);
      hrbp_pkg::ST_VER_T1:
        if (c == "T") st = hrbp_pkg::ST_VER_T2; else fail_with(hrbp_pkg::ERR_VERSION);
      hrbp_pkg::ST_VER_T2:
        if (c == "T") st = hrbp_pkg::ST_VER_P; else fail_with(hrbp_pkg::ERR_VERSION);
      hrbp_pkg::ST_VER_P:
        if (c == "P") st = hrbp_pkg::ST_VER_SLASH; else fail_with(hrbp_pkg::ERR_VERSION);
      hrbp_pkg::ST_VER_SLASH: begin
        if (c == "/") begin maj = '0; minr = '0; st = hrbp_pkg::ST_MAJ_START; end
        else fail_with(hrbp_pkg::ERR_VERSION);
      end
      hrbp_pkg::ST_MAJ_START: begin
        if (chr_digit(c)) begin maj = sat_mul10(maj, c); st = hrbp_pkg::ST_MAJ; end
        else fail_with(hrbp_pkg::ERR_DIGIT);
      end
      hrbp_pkg::ST_MAJ: begin
        if (c == ".") st = hrbp_pkg::ST_MIN_START;
        else if (chr_digit(c)) maj = sat_mul10(maj, c);
        else fail_with(hrbp_pkg::ERR_DIGIT);
      end
      hrbp_pkg::ST_MIN_START: begin
        if (chr_digit(c)) begin minr = sat_mul10(minr, c); st = hrbp_pkg::ST_MIN; end
        else fail_with(hrbp_pkg::ERR_DIGIT);
      end
      hrbp_pkg::ST_MIN: begin
        if (c == CR) st = hrbp_pkg::ST_NL1;
        else if (chr_digit(c)) minr = sat_mul10(minr, c);
        else fail_with(hrbp_pkg::ERR_DIGIT);
      end
      hrbp_pkg::ST_NL1, hrbp_pkg::ST_NL2:
        if (c == LF) st = hrbp_pkg::ST_LINE_START; else fail_with(hrbp_pkg::ERR_LF);
      hrbp_pkg::ST_LINE_START: begin
        if (c == CR) st = hrbp_pkg::ST_NL3;
        else if (hdr_seen && (c == " " || c == HT)) st = hrbp_pkg::ST_LWS;
        else if (!chr_token(c)) fail_with(hrbp_pkg::ERR_HDR_NAME);
        else begin
          hdr_seen = 1; in_len = 0; match_pos = '0;
          match_name(c);
          cls = hrbp_pkg::CLS_NAME; nh = 1'b1; st = hrbp_pkg::ST_NAME;
        end
      end
      hrbp_pkg::ST_NAME: begin
        if (c == ":") begin
          if (match_pos == LEN_HDR_CHARS) begin in_len = 1; len_ok = 0; clen = '0; end
          st = hrbp_pkg::ST_SPACE;
        end else if (chr_token(c)) begin
          match_name(c);
          cls = hrbp_pkg::CLS_NAME;
        end else fail_with(hrbp_pkg::ERR_HDR_NAME);
      end
      hrbp_pkg::ST_SPACE, hrbp_pkg::ST_LWS, hrbp_pkg::ST_VALUE: begin
        if (c == CR) st = hrbp_pkg::ST_NL2;
        else if (st != hrbp_pkg::ST_VALUE &&
                 (c == " " || (st == hrbp_pkg::ST_LWS && c == HT))) ;
        else if (chr_ctl(c)) fail_with(hrbp_pkg::ERR_VAL_CTL);
        else begin
          length_octet(c);
          cls = hrbp_pkg::CLS_VALUE; st = hrbp_pkg::ST_VALUE;
        end
      end
      hrbp_pkg::ST_NL3: begin
        if (c != LF) fail_with(hrbp_pkg::ERR_LF);
        else if (len_ok) begin
          bcount = '0;
          st = (clen > 0) ? hrbp_pkg::ST_BODY : hrbp_pkg::ST_DONE;
        end else if (body_req) fail_with(hrbp_pkg::ERR_BODY);
        else st = hrbp_pkg::ST_DONE;
      end
      hrbp_pkg::ST_BODY: begin
        cls = hrbp_pkg::CLS_BODY;
        bcount = (bcount + 1) & 64'hFFFF_FFFF;
        if (bcount >= clen) st = hrbp_pkg::ST_DONE;
      end
      default: ;
    endcase
    r.byte_class = cls;
    r.data_out = c;
    r.new_header = nh;
    r.done_res = (st == hrbp_pkg::ST_DONE);
    r.error_code = err;
    r.version_major = maj;
    r.version_minor = minr;
    r.body_length = len_ok ? clen[31:0] : 32'd0;
  endtask

  // driver: presents queued words, predicts each as it goes out
  always @(posedge clk) begin
    parse_result_t r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() > 0 && (no_idle || $urandom_range(0, 99) >= 17)) begin
        parse_word(pending_words[0], r);
        expected_results.insert(expected_results.size(), r);
        in_ch.valid <= 1'b1;
        in_ch.func <= pending_words[0].func;
        in_ch.data_byte <= pending_words[0].octet;
        void'(pending_words.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: random backpressure and word compare
  always @(posedge clk) begin
    parse_result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.byte_class, out_ch.data_out, out_ch.new_header, out_ch.done_res,
                out_ch.error_code, out_ch.version_major, out_ch.version_minor,
                out_ch.body_length};
        if (expected_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected word: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      out_ch.ready <= no_idle || $urandom_range(0, 99) >= 17;
    end
  end

  // message building helpers
  task automatic add_byte(logic [7:0] b);
    msg_buf.insert(msg_buf.size(), b);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_crlf();
    add_byte(CR);
    add_byte(LF);
  endtask

  task automatic flush_msg(bit corrupt);
    int pos;
    if (corrupt && msg_buf.size() > 0) begin
      pos = $urandom_range(0, msg_buf.size() - 1);
      msg_buf[pos] = 8'($urandom_range(0, 255));
    end
    pending_words.insert(pending_words.size(), '{1'b1, 8'($urandom_range(0, 255))});
    foreach (msg_buf[i]) pending_words.insert(pending_words.size(), '{1'b0, msg_buf[i]});
    msg_buf.delete();
  endtask

  function automatic logic [7:0] rand_token();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!chr_token(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_text();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 255)); while (c == 8'd127);
    return c;
  endfunction

  task automatic add_len_name();
    logic [7:0] c;
    for (int i = 0; i < LEN_HDR_CHARS; i++) begin
      c = LEN_HDR[8*(LEN_HDR_CHARS-1-i) +: 8];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      add_byte(c);
    end
  endtask

  // well-formed request with random content, followed by its body and up to two extra octets
  task automatic add_request();
    int nhdr, blen, kind, v;
    blen = 0;
    repeat ($urandom_range(1, 6)) add_byte(rand_token());
    add_byte(" ");
    repeat ($urandom_range(1, 8)) add_byte(rand_text());
    add_str(" HTTP/");
    repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range("0", "9")));
    add_byte(".");
    repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range("0", "9")));
    add_crlf();
    nhdr = $urandom_range(0, 3);
    for (int h = 0; h < nhdr; h++) begin
      if ($urandom_range(0, 1)) begin
        add_len_name();
        add_byte(":");
        repeat ($urandom_range(0, 2)) add_byte(" ");
        kind = $urandom_range(0, 9);
        v = $urandom_range(0, 6);
        blen = 0;
        case (kind)
          6: add_str("4294967296");
          7: add_str("3 ");
          8: ;
          9: begin
            add_str("1"); add_crlf(); add_byte($urandom_range(0, 1) ? " " : HT);
            add_str("2");
            blen = 12;
          end
          default: begin
            if ($urandom_range(0, 3) == 0) add_str("00");
            add_str($sformatf("%0d", v));
            blen = v;
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) add_byte(rand_token());
        add_byte(":");
        repeat ($urandom_range(0, 2)) add_byte(" ");
        repeat ($urandom_range(0, 6)) add_byte(rand_text());
        if ($urandom_range(0, 4) == 0) begin
          add_crlf(); add_byte(HT);
          repeat ($urandom_range(1, 3)) add_byte(rand_text());
        end
      end
      add_crlf();
    end
    add_crlf();
    repeat (blen) add_byte(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_body_req(logic v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    body_req = v;
  endtask

  task automatic random_phase(int words);
    int target;
    target = pending_words.size() + words;
    while (pending_words.size() < target) begin
      add_request();
      flush_msg($urandom_range(0, 99) < 25);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    body_req = 1'b0;
    clear_parser();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: version saturation, body, tab after colon, bad method, errors
    write_body_req(1'b0);
    no_idle = 1'b1;
    add_str("G H HTTP/999.300"); add_crlf(); add_str("Content-Length: 1"); add_crlf();
    add_crlf(); add_byte(8'hff); flush_msg(0);
    add_str("P / HTTP/1.0"); add_crlf(); add_str("a:"); add_byte(HT);
    flush_msg(0);
    add_byte(8'h80); flush_msg(0);
    add_str("A "); add_byte(8'h00); flush_msg(0);
    add_str("A / HTTP/1.1"); add_crlf(); add_crlf(); add_byte(8'h00); flush_msg(0);
    add_str("B / HTTP/1.1"); add_crlf(); add_str("Content-Length: 4294967295"); add_crlf();
    add_crlf(); add_str("xyz"); flush_msg(0);
    add_str("C / HTTPx"); flush_msg(0);
    add_str("D / HTTP/1.1"); add_byte(LF); flush_msg(0);
    wait_drained();
    no_idle = 1'b0;
    random_phase(35);

    write_body_req(1'b1);
    add_str("E / HTTP/1.1"); add_crlf(); add_str("Content-length:0"); add_crlf(); add_crlf();
    flush_msg(0);
    add_str("F / HTTP/1.1"); add_crlf(); add_crlf(); flush_msg(0);
    random_phase(30);
    no_idle = 1'b1;
    random_phase(15);
    wait_drained();
    no_idle = 1'b0;

    write_body_req(1'b0);
    random_phase(35);
    wait_drained();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
